### hw/rtl/htd_pkg.sv
// Shared types and constants of the Huffman tree decoder.
package htd_pkg;

   // Longest code that an insert word walks; longer lengths are clipped to it.
   localparam int MAX_CODE_LEN = 32;
   // Width of the code field; bit positions at or above it read as zero.
   localparam int CODE_BITS = 32;
   // Bits of one compressed byte and the position of the first one taken.
   localparam int BYTE_BITS = 8;
   localparam int BYTE_TOP_BIT = 7;

   // Function codes of an input word.
   typedef enum logic [1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_INSERT = 2'd1,
      FUNC_DECODE = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   // Status codes of a result word.
   typedef enum logic [2:0] {
      ST_SYMBOL   = 3'd0,
      ST_INSERTED = 3'd1,
      ST_FULL     = 3'd2,
      ST_DEAD     = 3'd3,
      ST_CLEARED  = 3'd4
   } status_type;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_INS_START,
      OP_DEC_START,
      OP_DEC_STEP,
      OP_DEC_LEAF,
      OP_INS_STEP,
      OP_INS_SETSYM,
      OP_INS_LINK,
      OP_INS_FILL
   } op_type;

   // Command from the controller to the datapath.
   typedef struct packed {
      logic       load;
      op_type     op;
      logic       emit;
      status_type emit_status;
      logic       flush;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic ev_leaf;
      logic ev_dead;
      logic byte_done;
      logic rem_zero;
      logic child_zero;
      logic fits;
      logic out_free;
      logic pend_valid;
   } stat_type;

endpackage

### hw/rtl/huffman_tree_decoder_unit.sv
// Top level of the Huffman tree decoder: controller plus datapath.
//
// Huffman decoder with the code tree kept in a node table of NODE_COUNT entries
// (root in flip-flops, all other nodes in one RAM, so no clearing pass is needed
// after reset). Each input word is handled on its own: a clear empties the tree; an
// insert of an L-bit code makes one node-table read per bit walked and one write
// per node created or changed; a decode byte makes at most one node-table read
// per bit, plus one to resume a walk. Results leave through an output register,
// and the next word is accepted while the last result still waits. Each word's
// results are delivered in order, the final one marked by rsp_tlast; a decode
// byte that reaches no leaf and hits no dead path gives no result.
module huffman_tree_decoder_unit #(
   parameter int NODE_COUNT = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] symbol, [13:8] code_length, [45:14] code_bits, [53:46] data_byte
   input  logic [55:0] req_tdata,
   // [1:0] func
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] decoded_symbol
   output logic [7:0]  rsp_tdata,
   // [2:0] status
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast
);

   import htd_pkg::*;

   cmd_type    cmd;
   stat_type   stat;
   status_type rsp_status;

   htd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_func  (func_type'(req_tuser)),
      .stat      (stat),
      .cmd       (cmd)
   );

   htd_datapath #(
      .NODE_COUNT(NODE_COUNT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_symbol     (req_tdata[7:0]),
      .req_code_length(req_tdata[13:8]),
      .req_code_bits  (req_tdata[45:14]),
      .req_data_byte  (req_tdata[53:46]),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_status     (rsp_status),
      .rsp_symbol     (rsp_tdata),
      .rsp_last       (rsp_tlast)
   );

   assign rsp_tuser = rsp_status;

endmodule

### hw/rtl/htd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module htd_ram #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### hw/rtl/htd_datapath.sv
// Datapath of the Huffman tree decoder: node table, walk registers and result buffers.
module htd_datapath #(
   parameter int NODE_COUNT = 512
) (
   input  logic                 clock,
   input  logic                 reset,
   input  htd_pkg::cmd_type     cmd,
   output htd_pkg::stat_type    stat,
   input  logic [7:0]           req_symbol,
   input  logic [5:0]           req_code_length,
   input  logic [31:0]          req_code_bits,
   input  logic [7:0]           req_data_byte,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output htd_pkg::status_type  rsp_status,
   output logic [7:0]           rsp_symbol,
   output logic                 rsp_last
);

   import htd_pkg::*;

   localparam int IW = $clog2(NODE_COUNT);
   localparam int CW = $clog2(NODE_COUNT + 1);
   localparam int SW = $clog2(NODE_COUNT + 64);
   localparam int EW = 8 + 2 * IW;

   // Item registers.
   logic [7:0]    sym_ff, sym_in;
   logic [31:0]   code_ff, code_in;
   logic [7:0]    data_ff, data_in;
   logic [5:0]    rem_ff, rem_in;
   logic [5:0]    pos_ff, pos_in;
   logic [3:0]    cnt_ff, cnt_in;

   // Walk registers.
   logic [IW-1:0] walk_ff, walk_in;
   logic [IW-1:0] cur_idx_ff, cur_idx_in;
   logic          cur_is_root_ff, cur_is_root_in;
   logic          need_check_ff, need_check_in;
   logic [CW-1:0] nodes_used_ff, nodes_used_in;

   // Root node, held in flip-flops so that reset gives it at once.
   logic [IW-1:0] root_left_ff, root_left_in;
   logic [IW-1:0] root_right_ff, root_right_in;
   logic [7:0]    root_sym_ff, root_sym_in;

   // Pending result and output register.
   logic          pend_valid_ff, pend_valid_in;
   status_type    pend_status_ff, pend_status_in;
   logic [7:0]    pend_sym_ff, pend_sym_in;
   logic          out_valid_ff, out_valid_in;
   status_type    out_status_ff, out_status_in;
   logic [7:0]    out_sym_ff, out_sym_in;
   logic          out_last_ff, out_last_in;

   // Node table access.
   logic          ram_wr_en;
   logic          ram_rd_en;
   logic [IW-1:0] ram_rd_addr;
   logic [EW-1:0] ram_rd_data;
   logic          ent_wr;
   logic [IW-1:0] ent_idx;
   logic [EW-1:0] ent_data;

   // Decoded views.
   logic [EW-1:0] cur_entry;
   logic [IW-1:0] cur_left, cur_right, rd_left, rd_right;
   logic [7:0]    cur_sym, rd_sym;
   logic          code_bit, byte_bit;
   logic [IW-1:0] ins_child, dec_child, new_idx, next_idx;
   logic [CW-1:0] nodes_used_p1;
   logic [SW-1:0] need_total;
   logic [5:0]    eff_len;
   logic [7:0]    emit_sym;
   logic          push;

   htd_ram #(
      .WIDTH(EW),
      .DEPTH(NODE_COUNT)
   ) u_node_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ent_idx),
      .wr_data(ent_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // Current node entry comes from the root flip-flops or the last RAM read.
   assign cur_entry = cur_is_root_ff ? {root_sym_ff, root_right_ff, root_left_ff} : ram_rd_data;
   assign cur_left  = cur_entry[IW-1:0];
   assign cur_right = cur_entry[2*IW-1:IW];
   assign cur_sym   = cur_entry[EW-1:2*IW];
   assign rd_left   = ram_rd_data[IW-1:0];
   assign rd_right  = ram_rd_data[2*IW-1:IW];
   assign rd_sym    = ram_rd_data[EW-1:2*IW];

   // Code bit at the current position, zero above the code field.
   assign code_bit = (pos_ff < 6'(CODE_BITS)) ? code_ff[pos_ff[$clog2(CODE_BITS)-1:0]] : 1'b0;
   assign byte_bit = data_ff[3'(BYTE_TOP_BIT) - cnt_ff[2:0]];

   assign ins_child     = code_bit ? cur_right : cur_left;
   assign dec_child     = byte_bit ? cur_right : cur_left;
   assign new_idx       = nodes_used_ff[IW-1:0];
   assign nodes_used_p1 = nodes_used_ff + CW'(1);
   assign next_idx      = nodes_used_p1[IW-1:0];
   assign need_total    = SW'(nodes_used_ff) + SW'(rem_ff);

   // Effective code length, clipped to the longest supported code.
   always_comb begin
      if ({1'b0, req_code_length} > 7'(MAX_CODE_LEN)) begin
         eff_len = 6'(MAX_CODE_LEN);
      end else begin
         eff_len = req_code_length;
      end
   end

   // Status toward the controller.
   always_comb begin
      stat.ev_leaf    = need_check_ff && (rd_left == '0) && (rd_right == '0);
      stat.ev_dead    = (dec_child == '0);
      stat.byte_done  = (cnt_ff == 4'(BYTE_BITS));
      stat.rem_zero   = (rem_ff == 6'd0);
      stat.child_zero = (ins_child == '0);
      stat.fits       = (need_total <= SW'(NODE_COUNT));
      stat.out_free   = !out_valid_ff || rsp_tready;
      stat.pend_valid = pend_valid_ff;
   end

   // Next-state logic of the walk and the node table.
   always_comb begin
      sym_in         = sym_ff;
      code_in        = code_ff;
      data_in        = data_ff;
      rem_in         = rem_ff;
      pos_in         = pos_ff;
      cnt_in         = cnt_ff;
      walk_in        = walk_ff;
      cur_idx_in     = cur_idx_ff;
      cur_is_root_in = cur_is_root_ff;
      need_check_in  = need_check_ff;
      nodes_used_in  = nodes_used_ff;
      root_left_in   = root_left_ff;
      root_right_in  = root_right_ff;
      root_sym_in    = root_sym_ff;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = walk_ff;
      ent_wr         = 1'b0;
      ent_idx        = cur_idx_ff;
      ent_data       = cur_entry;

      if (cmd.load) begin
         sym_in  = req_symbol;
         code_in = req_code_bits;
         data_in = req_data_byte;
      end

      case (cmd.op)
         OP_CLEAR: begin
            root_left_in  = '0;
            root_right_in = '0;
            root_sym_in   = '0;
            nodes_used_in = CW'(1);
            walk_in       = '0;
         end
         OP_INS_START: begin
            cur_is_root_in = 1'b1;
            cur_idx_in     = '0;
            rem_in         = eff_len;
            pos_in         = eff_len - 6'd1;
         end
         OP_DEC_START: begin
            cnt_in         = 4'd0;
            need_check_in  = 1'b0;
            cur_is_root_in = (walk_ff == '0);
            ram_rd_en      = (walk_ff != '0);
            ram_rd_addr    = walk_ff;
         end
         OP_DEC_STEP: begin
            cnt_in = cnt_ff + 4'd1;
            if (dec_child == '0) begin
               walk_in        = '0;
               cur_is_root_in = 1'b1;
               need_check_in  = 1'b0;
            end else begin
               walk_in        = dec_child;
               ram_rd_en      = 1'b1;
               ram_rd_addr    = dec_child;
               cur_is_root_in = 1'b0;
               need_check_in  = 1'b1;
            end
         end
         OP_DEC_LEAF: begin
            walk_in        = '0;
            cur_is_root_in = 1'b1;
            need_check_in  = 1'b0;
         end
         OP_INS_STEP: begin
            ram_rd_en      = 1'b1;
            ram_rd_addr    = ins_child;
            cur_idx_in     = ins_child;
            cur_is_root_in = 1'b0;
            rem_in         = rem_ff - 6'd1;
            pos_in         = pos_ff - 6'd1;
         end
         OP_INS_SETSYM: begin
            ent_wr   = 1'b1;
            ent_idx  = cur_idx_ff;
            ent_data = {sym_ff, cur_right, cur_left};
         end
         OP_INS_LINK: begin
            ent_wr  = 1'b1;
            ent_idx = cur_idx_ff;
            if (code_bit) begin
               ent_data = {cur_sym, new_idx, cur_left};
            end else begin
               ent_data = {cur_sym, cur_right, new_idx};
            end
            rem_in = rem_ff - 6'd1;
            pos_in = pos_ff - 6'd1;
         end
         OP_INS_FILL: begin
            ent_wr        = 1'b1;
            ent_idx       = new_idx;
            nodes_used_in = nodes_used_p1;
            if (rem_ff == 6'd0) begin
               ent_data = {sym_ff, {IW{1'b0}}, {IW{1'b0}}};
            end else begin
               if (code_bit) begin
                  ent_data = {8'h00, next_idx, {IW{1'b0}}};
               end else begin
                  ent_data = {8'h00, {IW{1'b0}}, next_idx};
               end
               rem_in = rem_ff - 6'd1;
               pos_in = pos_ff - 6'd1;
            end
         end
         default: begin
         end
      endcase

      // The root lives in flip-flops; every other node in the RAM.
      if (ent_wr && (ent_idx == '0)) begin
         root_left_in  = ent_data[IW-1:0];
         root_right_in = ent_data[2*IW-1:IW];
         root_sym_in   = ent_data[EW-1:2*IW];
      end
   end

   assign ram_wr_en = ent_wr && (ent_idx != '0);

   // Result path: a new result parks in the pending slot, pushing the older
   // one out; a flush sends the pending result out as the final one.
   assign emit_sym = (cmd.emit_status == ST_SYMBOL) ? rd_sym : 8'h00;
   assign push     = (cmd.emit && pend_valid_ff) || cmd.flush;

   always_comb begin
      pend_valid_in  = pend_valid_ff;
      pend_status_in = pend_status_ff;
      pend_sym_in    = pend_sym_ff;
      out_valid_in   = out_valid_ff;
      out_status_in  = out_status_ff;
      out_sym_in     = out_sym_ff;
      out_last_in    = out_last_ff;

      if (push) begin
         out_valid_in  = 1'b1;
         out_status_in = pend_status_ff;
         out_sym_in    = pend_sym_ff;
         out_last_in   = cmd.flush;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end

      if (cmd.emit) begin
         pend_valid_in  = 1'b1;
         pend_status_in = cmd.emit_status;
         pend_sym_in    = emit_sym;
      end else if (cmd.flush) begin
         pend_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         nodes_used_ff <= CW'(1);
         walk_ff       <= '0;
         root_left_ff  <= '0;
         root_right_ff <= '0;
         root_sym_ff   <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         nodes_used_ff <= nodes_used_in;
         walk_ff       <= walk_in;
         root_left_ff  <= root_left_in;
         root_right_ff <= root_right_in;
         root_sym_ff   <= root_sym_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      sym_ff         <= sym_in;
      code_ff        <= code_in;
      data_ff        <= data_in;
      rem_ff         <= rem_in;
      pos_ff         <= pos_in;
      cnt_ff         <= cnt_in;
      cur_idx_ff     <= cur_idx_in;
      cur_is_root_ff <= cur_is_root_in;
      need_check_ff  <= need_check_in;
      pend_status_ff <= pend_status_in;
      pend_sym_ff    <= pend_sym_in;
      out_status_ff  <= out_status_in;
      out_sym_ff     <= out_sym_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_symbol = out_sym_ff;
   assign rsp_last   = out_last_ff;

endmodule

### hw/rtl/htd_ctrl.sv
// Controller state machine of the Huffman tree decoder.
module htd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  htd_pkg::func_type  req_func,
   input  htd_pkg::stat_type  stat,
   output htd_pkg::cmd_type   cmd
);

   import htd_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DEC_WALK,
      S_INS_WALK,
      S_INS_FILL,
      S_FLUSH
   } state_type;

   state_type state_ff, state_in;
   logic      can_emit;

   // A new result fits if the pending slot is free or can move on.
   assign can_emit   = !stat.pend_valid || stat.out_free;
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in        = state_ff;
      cmd.load        = 1'b0;
      cmd.op          = OP_NONE;
      cmd.emit        = 1'b0;
      cmd.emit_status = ST_SYMBOL;
      cmd.flush       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               case (req_func)
                  FUNC_CLEAR: begin
                     cmd.op          = OP_CLEAR;
                     cmd.emit        = 1'b1;
                     cmd.emit_status = ST_CLEARED;
                     state_in        = S_FLUSH;
                  end
                  FUNC_INSERT: begin
                     cmd.op   = OP_INS_START;
                     state_in = S_INS_WALK;
                  end
                  FUNC_DECODE: begin
                     cmd.op   = OP_DEC_START;
                     state_in = S_DEC_WALK;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // One bit per cycle if results can move; a leaf is its own step.
         S_DEC_WALK: begin
            if (stat.ev_leaf) begin
               if (can_emit) begin
                  cmd.op          = OP_DEC_LEAF;
                  cmd.emit        = 1'b1;
                  cmd.emit_status = ST_SYMBOL;
               end
            end else if (stat.byte_done) begin
               state_in = S_FLUSH;
            end else if (stat.ev_dead) begin
               if (can_emit) begin
                  cmd.op          = OP_DEC_STEP;
                  cmd.emit        = 1'b1;
                  cmd.emit_status = ST_DEAD;
               end
            end else begin
               cmd.op = OP_DEC_STEP;
            end
         end

         // Follow existing nodes until the code ends or a child is missing.
         S_INS_WALK: begin
            if (stat.rem_zero) begin
               cmd.op          = OP_INS_SETSYM;
               cmd.emit        = 1'b1;
               cmd.emit_status = ST_INSERTED;
               state_in        = S_FLUSH;
            end else if (stat.child_zero) begin
               if (stat.fits) begin
                  cmd.op   = OP_INS_LINK;
                  state_in = S_INS_FILL;
               end else begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = ST_FULL;
                  state_in        = S_FLUSH;
               end
            end else begin
               cmd.op = OP_INS_STEP;
            end
         end

         // Write one new node per cycle; the last one carries the symbol.
         S_INS_FILL: begin
            cmd.op = OP_INS_FILL;
            if (stat.rem_zero) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = ST_INSERTED;
               state_in        = S_FLUSH;
            end
         end

         // Send the held result out as the final word of the item.
         S_FLUSH: begin
            if (!stat.pend_valid) begin
               state_in = S_IDLE;
            end else if (stat.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the Huffman tree decoder: directed trees, then random code tables.
module testbench;
   import htd_pkg::*;

   localparam int NODE_COUNT     = 512;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_ITEMS   = 185;
   localparam int DRAIN_CYCLES   = 40;

   // One result word as the bench expects to see it.
   typedef struct packed {
      status_type status;
      logic [7:0] symbol;
      logic       last;
   } result_word_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [7:0] symbol, [13:8] code_length, [45:14] code_bits, [53:46] data_byte
   logic [55:0] req_tdata  = '0;
   // [1:0] func
   logic [1:0]  req_tuser  = FUNC_CLEAR;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [7:0] decoded_symbol
   logic [7:0]  rsp_tdata;
   // [2:0] status
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   // Shadow copy of the code tree and of the decode walk.
   logic [8:0] tree_left   [NODE_COUNT];
   logic [8:0] tree_right  [NODE_COUNT];
   logic [7:0] tree_symbol [NODE_COUNT];
   logic [9:0] tree_size;
   logic [8:0] walk_pos;
   status_type last_insert_status = ST_INSERTED;

   result_word_type awaited_words [$];

   int tx_gap_max   = 0;
   int rx_stall_max = 0;
   int stall_left   = 0;
   int quiet_cycles = 0;
   int error_count  = 0;
   int items_sent   = 0;

   huffman_tree_decoder_unit #(
      .NODE_COUNT(NODE_COUNT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Empty the shadow tree to a lone root and send the walk back to it.
   function automatic void clear_tree_model();
      tree_left[0]   = '0;
      tree_right[0]  = '0;
      tree_symbol[0] = '0;
      tree_size      = 10'd1;
      walk_pos       = '0;
   endfunction

   function automatic result_word_type make_result(status_type status, logic [7:0] symbol);
      result_word_type r;
      r.status = status;
      r.symbol = symbol;
      r.last   = 1'b0;
      return r;
   endfunction

   // Walk the code from the root, count missing nodes, then build the path if it fits.
   function automatic status_type insert_into_model(logic [7:0] symbol, logic [5:0] len_in,
                                                    logic [31:0] code);
      int         len;
      int         needed;
      int         i;
      logic [8:0] node;
      logic [8:0] child;
      logic       go_right;
      len    = (int'(len_in) > MAX_CODE_LEN) ? MAX_CODE_LEN : int'(len_in);
      needed = 0;
      node   = '0;
      for (i = 0; i < len && needed == 0; i++) begin
         go_right = code[len - 1 - i];
         child    = go_right ? tree_right[node] : tree_left[node];
         if (child == '0)
            needed = len - i;
         else
            node = child;
      end
      if (int'(tree_size) + needed > NODE_COUNT)
         return ST_FULL;
      node = '0;
      for (i = 0; i < len; i++) begin
         go_right = code[len - 1 - i];
         child    = go_right ? tree_right[node] : tree_left[node];
         if (child == '0) begin
            child              = tree_size[8:0];
            tree_size          = tree_size + 10'd1;
            tree_left[child]   = '0;
            tree_right[child]  = '0;
            tree_symbol[child] = '0;
            if (go_right)
               tree_right[node] = child;
            else
               tree_left[node] = child;
         end
         node = child;
      end
      tree_symbol[node] = symbol;
      return ST_INSERTED;
   endfunction

   // Apply one accepted word to the shadow tree and queue the result words it causes.
   function automatic void predict_tree_results(func_type func, logic [7:0] symbol,
                                                logic [5:0] len, logic [31:0] code,
                                                logic [7:0] data);
      result_word_type found [8];
      result_word_type r;
      logic [8:0]      child;
      int              n;
      int              i;
      n = 0;
      case (func)
         FUNC_CLEAR: begin
            clear_tree_model();
            found[n] = make_result(ST_CLEARED, 8'h00);
            n++;
         end
         FUNC_INSERT: begin
            last_insert_status = insert_into_model(symbol, len, code);
            found[n] = make_result(last_insert_status, 8'h00);
            n++;
         end
         FUNC_DECODE: begin
            for (i = BYTE_TOP_BIT; i >= 0; i--) begin
               child = data[i] ? tree_right[walk_pos] : tree_left[walk_pos];
               if (child == '0) begin
                  // Dead path: report it and carry on from the root.
                  found[n] = make_result(ST_DEAD, 8'h00);
                  n++;
                  walk_pos = '0;
               end else begin
                  walk_pos = child;
                  if (tree_left[child] == '0 && tree_right[child] == '0) begin
                     found[n] = make_result(ST_SYMBOL, tree_symbol[child]);
                     n++;
                     walk_pos = '0;
                  end
               end
            end
         end
         default: ;
      endcase
      for (i = 0; i < n; i++) begin
         r      = found[i];
         r.last = (i == n - 1);
         awaited_words.insert(awaited_words.size(), r);
      end
   endfunction

   // Offer one word after a random gap and hold it until the decoder takes it.
   task automatic send_word(input func_type func, input logic [7:0] symbol,
                            input logic [5:0] len, input logic [31:0] code,
                            input logic [7:0] data);
      int gap;
      gap = $urandom_range(0, tx_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {2'b00, data, code, len, symbol};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_tree_results(func, symbol, len, code, data);
      if (func != FUNC_NONE)
         items_sent++;
   endtask

   task automatic do_clear();
      send_word(FUNC_CLEAR, 8'($urandom()), 6'($urandom()), $urandom(), 8'($urandom()));
   endtask

   // Code bits above the code length are filled with noise; they must not matter.
   task automatic do_insert(input logic [7:0] symbol, input logic [5:0] len,
                            input logic [31:0] code);
      logic [31:0] padded;
      padded = code;
      if (len < 6'd32)
         padded = code | ($urandom() << len);
      send_word(FUNC_INSERT, symbol, len, padded, 8'($urandom()));
   endtask

   task automatic do_decode(input logic [7:0] data);
      send_word(FUNC_DECODE, 8'($urandom()), 6'($urandom()), $urandom(), data);
   endtask

   task automatic do_unused();
      send_word(FUNC_NONE, 8'($urandom()), 6'($urandom()), $urandom(), 8'($urandom()));
   endtask

   // Build a complete prefix code by splitting random leaves, then load a share of it.
   task automatic load_random_code(input int leaves, input int max_depth, input int keep_pct);
      logic [31:0] codes [$];
      int          lens [$];
      logic [31:0] code;
      int          len;
      int          pick;
      int          k;
      codes.insert(codes.size(), 32'd0);
      lens.insert(lens.size(), 0);
      for (k = 1; k < leaves; k++) begin
         pick = $urandom_range(0, codes.size() - 1);
         if (lens[pick] < max_depth) begin
            code = codes[pick];
            len  = lens[pick];
            codes.delete(pick);
            lens.delete(pick);
            codes.insert(codes.size(), code << 1);
            lens.insert(lens.size(), len + 1);
            codes.insert(codes.size(), (code << 1) | 32'd1);
            lens.insert(lens.size(), len + 1);
         end
      end
      for (k = 0; k < codes.size(); k++) begin
         if ($urandom_range(1, 100) <= keep_pct)
            do_insert(8'($urandom()), 6'(lens[k]), codes[k]);
      end
   endtask

   // An empty tree turns every bit of a byte into a dead path; unused words do nothing.
   task automatic test_empty_tree();
      tx_gap_max   = 17;
      rx_stall_max = 17;
      do_clear();
      do_decode(8'hA5);
      do_unused();
   endtask

   // A zero-length code only labels the root, which is never a leaf of a walk.
   task automatic test_root_code();
      do_insert(8'hFF, 6'd0, 32'h0);
      do_decode(8'hFF);
   endtask

   // Codes 0 and 10 with 11 left missing: symbols, a dead path and a walk across bytes.
   task automatic test_short_codes();
      tx_gap_max   = 0;
      rx_stall_max = 0;
      do_clear();
      do_insert(8'h00, 6'd1, 32'b0);
      do_insert(8'hFF, 6'd2, 32'b10);
      do_decode(8'b0100_1101);
      do_decode(8'h00);
   endtask

   // Full-length codes, one given with an over-long length that gets clipped.
   task automatic test_long_codes();
      tx_gap_max   = 17;
      rx_stall_max = 17;
      do_clear();
      do_insert(8'hC3, 6'd32, 32'hFFFF_FFFF);
      do_insert(8'h3C, 6'd63, 32'h0000_0000);
      repeat (4) do_decode(8'hFF);
      do_decode(8'h00);
   endtask

   // Fill the node table with long codes until an insert no longer fits.
   task automatic test_table_full();
      rx_stall_max = 0;
      do_clear();
      do begin
         do_insert(8'($urandom()), 6'd32, $urandom());
      end while (last_insert_status != ST_FULL);
      // A code that needs no new node still goes in on a full table.
      do_insert(8'h5A, 6'd0, 32'h0);
      do_decode(8'($urandom()));
   endtask

   // Mostly complete random codes decoded from random bytes, with some noise mixed in.
   task automatic test_random_trees();
      int first_item;
      int leaves;
      int depth;
      int keep_pct;
      int words;
      int roll;
      first_item = items_sent;
      while (items_sent - first_item < RANDOM_ITEMS) begin
         tx_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 17;
         rx_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 17;
         leaves       = $urandom_range(1, 20);
         depth        = ($urandom_range(0, 4) == 0) ? 32 : $urandom_range(1, 10);
         keep_pct     = ($urandom_range(0, 3) == 0) ? 70 : 100;
         do_clear();
         load_random_code(leaves, depth, keep_pct);
         words = $urandom_range(4, 16);
         repeat (words) begin
            roll = $urandom_range(0, 19);
            if (roll < 16)
               do_decode(8'($urandom()));
            else if (roll < 18)
               do_insert(8'($urandom()), 6'($urandom_range(0, 63)), $urandom());
            else if (roll == 18)
               do_unused();
            else
               do_clear();
         end
      end
   endtask

   // Result side: random stalls per word, and each word checked against the oldest expectation.
   always @(posedge clock) begin : result_check
      result_word_type want;
      int              stall;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (awaited_words.size() == 0) begin
            $error("unexpected result word: status %0d, symbol %0d", rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            want = awaited_words.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata !== want.symbol) begin
               $error("decoded_symbol: expected %0d, actual %0d", want.symbol, rsp_tdata);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_tlast);
               error_count++;
            end
         end
         stall = $urandom_range(0, rx_stall_max);
         stall_left <= stall;
         rsp_tready <= (stall == 0);
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_left <= 0;
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: too long without any word moving on either side ends the run.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      clear_tree_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_empty_tree();
      test_root_code();
      test_short_codes();
      test_long_codes();
      test_table_full();
      test_random_trees();

      // Let every awaited word arrive, then watch a while for stray ones.
      req_tvalid <= 1'b0;
      while (awaited_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

### sim.f
hw/rtl/htd_pkg.sv
hw/rtl/htd_ram.sv
hw/rtl/htd_datapath.sv
hw/rtl/htd_ctrl.sv
hw/rtl/huffman_tree_decoder_unit.sv
verif/testbench.sv
